@@ src/slot_pool_allocator_macros.svh @@
// Assertion macros used by the slot pool allocator top level.
`ifndef SLOT_POOL_ALLOCATOR_MACROS_SVH
`define SLOT_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SPA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/spa_pkg.sv @@
// Types and codes of the slot pool allocator.
package spa_pkg;

  localparam int SLOT_W   = 10;
  localparam int CAP_REG_W = 11;
  localparam int BYTES_W  = 16;
  localparam int OFS_W    = 32;
  localparam int HWOUT_W  = 11;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_LOCATE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_INACTIVE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAT_CAP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_CAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAT_BYTES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_BYTES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_BYTES = 3'd4;

  typedef struct packed {
    logic [1:0]        mode;
    logic              pool;
    logic [SLOT_W-1:0] slot;
  } spa_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  granted_slot;
    logic [OFS_W-1:0]   byte_offset;
    logic [HWOUT_W-1:0] high_water;
  } spa_out_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DEC,
    S_POP,
    S_CHK,
    S_TRIM_RD,
    S_TRIM,
    S_MUL_A,
    S_MUL_B,
    S_SUM,
    S_OUT
  } spa_state_e;

endpackage

@@ src/spa_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module spa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/slot_pool_allocator.sv @@
// Top level of the slot pool allocator: sequencer, pool counters and offset arithmetic.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid_i/in_stall_o  | spa_in_t: mode, pool, slot
//  out     | output    | out_valid_o/out_stall_i| spa_out_t: status, slot, offset, hw
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One word at a time. A word rejected at decode goes straight to the output state, a free
// or locate of an inactive slot reads its flag first, an allocate from the high-water mark
// then computes the offset, an allocate from the free stack or a locate first pops the stack
// or checks the flag, and a free walks down over inactive slots to an active one or to zero.
// A stalled output word holds the next word in its last state until it leaves. After reset
// a clearing pass writes one flag entry a cycle (2048 at defaults), in_stall_o high.
`include "slot_pool_allocator_macros.svh"

module slot_pool_allocator
  import spa_pkg::*;
#(
  parameter int MAX_SLOTS  = 1024,
  parameter int POOL_COUNT = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  spa_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output spa_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTES_W-1:0]   cfg_data_i
);

  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int HW_W   = $clog2(MAX_SLOTS + 1);
  localparam int CAP_W  = (HW_W > CAP_REG_W) ? HW_W : CAP_REG_W;
  localparam int POOL_W = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  localparam int ADDR_W = POOL_W + IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam logic POOL1_OK = (POOL_COUNT > 1);

  // Configuration registers
  logic [CAP_REG_W-1:0] mat_cap_q, tex_cap_q;
  logic [BYTES_W-1:0]   mat_bytes_q, tex_bytes_q, hdr_bytes_q;

  spa_state_e           state_q, state_d;
  spa_in_t              item_q, item_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [1:0]           status_q, status_d;
  logic [SLOT_W-1:0]    granted_q, granted_d;
  logic [OFS_W-1:0]     offset_q, offset_d;
  logic [OFS_W-1:0]     prod_a_q, prod_a_d;
  logic [OFS_W-1:0]     prod_b_q, prod_b_d;
  logic [ADDR_W-1:0]    clr_q, clr_d;
  logic [HW_W-1:0]      hw_q [POOL_COUNT];
  logic [HW_W-1:0]      hw_d [POOL_COUNT];
  logic [HW_W-1:0]      dep_q [POOL_COUNT];
  logic [HW_W-1:0]      dep_d [POOL_COUNT];
  logic                 out_valid_q, out_valid_d;
  spa_out_t             out_q, out_d;

  logic                 flag_we, flag_wdata, flag_rdata;
  logic [ADDR_W-1:0]    flag_waddr, flag_raddr;
  logic                 stack_we;
  logic [ADDR_W-1:0]    stack_waddr, stack_raddr;
  logic [IDX_W-1:0]     stack_wdata, stack_rdata;

  logic [POOL_W-1:0]    pidx;
  logic                 pool_ok;
  logic [HW_W-1:0]      cur_hw, cur_dep;
  logic [CAP_W-1:0]     cap_raw, eff_cap, eff_cap0;
  logic [BYTES_W-1:0]   entry_bytes;
  logic [IDX_W+BYTES_W-1:0] mul_a;
  logic [CAP_W+BYTES_W-1:0] mul_b;

  spa_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .raddr_i (flag_raddr),
    .rdata_o (flag_rdata)
  );

  spa_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (stack_waddr),
    .wdata_i (stack_wdata),
    .raddr_i (stack_raddr),
    .rdata_o (stack_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pidx    = POOL_W'(item_q.pool);
  assign pool_ok = !item_q.pool || POOL1_OK;
  assign cur_hw  = hw_q[pidx];
  assign cur_dep = dep_q[pidx];

  // Clamp capacity registers to the storage size
  assign cap_raw  = CAP_W'(item_q.pool ? tex_cap_q : mat_cap_q);
  assign eff_cap  = (cap_raw > CAP_W'(MAX_SLOTS)) ? CAP_W'(MAX_SLOTS) : cap_raw;
  assign eff_cap0 = (CAP_W'(mat_cap_q) > CAP_W'(MAX_SLOTS)) ? CAP_W'(MAX_SLOTS)
                                                            : CAP_W'(mat_cap_q);

  assign entry_bytes = item_q.pool ? tex_bytes_q : mat_bytes_q;
  assign mul_a       = idx_q * entry_bytes;
  assign mul_b       = eff_cap0 * mat_bytes_q;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    status_d    = status_q;
    granted_d   = granted_q;
    offset_d    = offset_q;
    prod_a_d    = prod_a_q;
    prod_b_d    = prod_b_q;
    clr_d       = clr_q;
    hw_d        = hw_q;
    dep_d       = dep_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    flag_we     = 1'b0;
    flag_waddr  = {pidx, idx_q};
    flag_wdata  = 1'b0;
    flag_raddr  = {pidx, idx_q};
    stack_we    = 1'b0;
    stack_waddr = {pidx, IDX_W'(cur_dep)};
    stack_wdata = idx_q;
    stack_raddr = {pidx, IDX_W'(cur_dep - HW_W'(1))};

    case (state_q)
      S_CLR: begin
        flag_we    = 1'b1;
        flag_waddr = clr_q;
        clr_d      = clr_q + ADDR_W'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        status_d  = ST_RANGE;
        granted_d = item_q.slot;
        offset_d  = '0;
        if (!pool_ok) begin
          state_d = S_OUT;
        end else if (item_q.mode == MODE_ALLOC) begin
          if (cur_dep != '0) begin
            // pop the most recently freed index
            dep_d[pidx] = cur_dep - HW_W'(1);
            state_d     = S_POP;
          end else if (CAP_W'(cur_hw) >= eff_cap) begin
            status_d  = ST_FULL;
            granted_d = '0;
            state_d   = S_OUT;
          end else begin
            idx_d       = IDX_W'(cur_hw);
            flag_we     = 1'b1;
            flag_waddr  = {pidx, IDX_W'(cur_hw)};
            flag_wdata  = 1'b1;
            hw_d[pidx]  = cur_hw + HW_W'(1);
            status_d    = ST_OK;
            granted_d   = SLOT_W'(cur_hw);
            state_d     = S_MUL_A;
          end
        end else if (item_q.mode inside {MODE_FREE, MODE_LOCATE}) begin
          if (CAP_W'(item_q.slot) >= eff_cap) begin
            state_d = S_OUT;
          end else begin
            idx_d      = IDX_W'(item_q.slot);
            flag_raddr = {pidx, IDX_W'(item_q.slot)};
            state_d    = S_CHK;
          end
        end else begin
          state_d = S_OUT;
        end
      end

      S_POP: begin
        idx_d      = stack_rdata;
        flag_we    = 1'b1;
        flag_waddr = {pidx, stack_rdata};
        flag_wdata = 1'b1;
        if (HW_W'(stack_rdata) + HW_W'(1) > cur_hw) begin
          hw_d[pidx] = HW_W'(stack_rdata) + HW_W'(1);
        end
        status_d  = ST_OK;
        granted_d = SLOT_W'(stack_rdata);
        state_d   = S_MUL_A;
      end

      S_CHK: begin
        if (!flag_rdata) begin
          status_d = ST_INACTIVE;
          state_d  = S_OUT;
        end else if (item_q.mode == MODE_LOCATE) begin
          status_d = ST_OK;
          state_d  = S_MUL_A;
        end else begin
          flag_we = 1'b1;
          // drop the push once the stack is full
          if (32'(cur_dep) < MAX_SLOTS) begin
            stack_we    = 1'b1;
            dep_d[pidx] = cur_dep + HW_W'(1);
          end
          status_d = ST_OK;
          state_d  = S_TRIM_RD;
        end
      end

      S_TRIM_RD: begin
        if (cur_hw == '0) begin
          state_d = S_OUT;
        end else begin
          flag_raddr = {pidx, IDX_W'(cur_hw - HW_W'(1))};
          state_d    = S_TRIM;
        end
      end

      S_TRIM: begin
        // flag of slot cur_hw-1 is on the read port
        if (flag_rdata) begin
          state_d = S_OUT;
        end else begin
          hw_d[pidx] = cur_hw - HW_W'(1);
          if (cur_hw == HW_W'(1)) begin
            state_d = S_OUT;
          end else begin
            flag_raddr = {pidx, IDX_W'(cur_hw - HW_W'(2))};
          end
        end
      end

      S_MUL_A: begin
        prod_a_d = OFS_W'(mul_a);
        state_d  = S_MUL_B;
      end

      S_MUL_B: begin
        prod_b_d = item_q.pool ? OFS_W'(mul_b) : '0;
        state_d  = S_SUM;
      end

      S_SUM: begin
        offset_d = OFS_W'(hdr_bytes_q) + prod_a_q + prod_b_q;
        state_d  = S_OUT;
      end

      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d.status       = status_q;
          out_d.granted_slot = granted_q;
          out_d.byte_offset  = offset_q;
          out_d.high_water   = pool_ok ? HWOUT_W'(cur_hw) : '0;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < POOL_COUNT; i++) begin
        hw_q[i]  <= '0;
        dep_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      hw_q        <= hw_d;
      dep_q       <= dep_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_cap_q   <= CAP_REG_W'(1024);
      tex_cap_q   <= CAP_REG_W'(1024);
      mat_bytes_q <= BYTES_W'(256);
      tex_bytes_q <= BYTES_W'(64);
      hdr_bytes_q <= BYTES_W'(64);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MAT_CAP:   mat_cap_q   <= cfg_data_i[CAP_REG_W-1:0];
        CFG_TEX_CAP:   tex_cap_q   <= cfg_data_i[CAP_REG_W-1:0];
        CFG_MAT_BYTES: mat_bytes_q <= cfg_data_i;
        CFG_TEX_BYTES: tex_bytes_q <= cfg_data_i;
        CFG_HDR_BYTES: hdr_bytes_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    idx_q     <= idx_d;
    status_q  <= status_d;
    granted_q <= granted_d;
    offset_q  <= offset_d;
    prod_a_q  <= prod_a_d;
    prod_b_q  <= prod_b_d;
    out_q     <= out_d;
  end

  `SPA_ASSERT_NXT(a_accept_decodes, in_valid_i && !in_stall_o, state_q == S_DEC, "accepted word not decoded")
  `SPA_ASSERT_IMP(a_trim_nonzero, state_q == S_TRIM, cur_hw != '0, "trim walk below slot zero")
  `SPA_ASSERT_IMP(a_hw_bound, state_q == S_OUT && pool_ok, 32'(cur_hw) <= MAX_SLOTS, "high-water count beyond pool size")
  `SPA_ASSERT_IMP(a_dep_bound, state_q == S_OUT && pool_ok, 32'(cur_dep) <= MAX_SLOTS, "free stack depth beyond pool size")
  `SPA_ASSERT_NXT(a_out_loads, state_q == S_OUT && !(out_valid_q && out_stall_i), out_valid_q && state_q == S_IDLE, "result not loaded into output register")

endmodule

@@ verif/tb_top.sv @@
// Self-checking bench for the slot pool allocator: predicted replies against the block.
`timescale 1ns / 100ps

module tb_top;
  import spa_pkg::*;

  localparam int SLOTS_PER_POOL = 1024;
  localparam int WATCHDOG_CYCLES = 10000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Shadow of both pools: predicts each reply and keeps the replies still owed.
  class pool_tracker;
    logic [CAP_REG_W-1:0] cap_reg [2];
    logic [BYTES_W-1:0]   entry_bytes [2];
    logic [BYTES_W-1:0]   hdr_bytes;
    bit                   in_use [2][SLOTS_PER_POOL];
    int                   freed [2][$];
    int                   mark [2];
    spa_out_t             owed [$];
    int                   mismatches;
    int                   replies;

    function new();
      cap_reg[0] = 11'd1024;
      cap_reg[1] = 11'd1024;
      entry_bytes[0] = 16'd256;
      entry_bytes[1] = 16'd64;
      hdr_bytes = 16'd64;
      mark[0] = 0;
      mark[1] = 0;
      mismatches = 0;
      replies = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTES_W-1:0] val);
      case (idx)
        CFG_MAT_CAP:   cap_reg[0] = val[CAP_REG_W-1:0];
        CFG_TEX_CAP:   cap_reg[1] = val[CAP_REG_W-1:0];
        CFG_MAT_BYTES: entry_bytes[0] = val;
        CFG_TEX_BYTES: entry_bytes[1] = val;
        CFG_HDR_BYTES: hdr_bytes = val;
        default: ;
      endcase
    endfunction

    function int usable(int p);
      int c;
      c = int'(cap_reg[p]);
      return (c > SLOTS_PER_POOL) ? SLOTS_PER_POOL : c;
    endfunction

    function logic [OFS_W-1:0] offset_of(int p, int s);
      longint unsigned acc;
      acc = longint'(hdr_bytes);
      if (p != 0) acc += longint'(usable(0)) * longint'(entry_bytes[0]);
      acc += longint'(s) * longint'(entry_bytes[p]);
      return acc[OFS_W-1:0];
    endfunction

    function spa_out_t predict(spa_in_t w);
      spa_out_t o;
      int p;
      int s;
      int cap;
      int idx;
      p = int'(w.pool);
      s = int'(w.slot);
      cap = usable(p);
      o.status = ST_RANGE;
      o.granted_slot = w.slot;
      o.byte_offset = '0;
      case (w.mode)
        MODE_ALLOC: begin
          if (freed[p].size() > 0) begin
            // most recently freed index first, even if now beyond capacity
            idx = freed[p][$];
            freed[p].delete(freed[p].size() - 1);
            in_use[p][idx] = 1'b1;
            if (idx + 1 > mark[p]) mark[p] = idx + 1;
            o.status = ST_OK;
            o.granted_slot = SLOT_W'(idx);
            o.byte_offset = offset_of(p, idx);
          end else if (mark[p] >= cap) begin
            o.status = ST_FULL;
            o.granted_slot = '0;
          end else begin
            idx = mark[p];
            in_use[p][idx] = 1'b1;
            mark[p] = idx + 1;
            o.status = ST_OK;
            o.granted_slot = SLOT_W'(idx);
            o.byte_offset = offset_of(p, idx);
          end
        end
        MODE_FREE, MODE_LOCATE: begin
          if (s >= cap) begin
            o.status = ST_RANGE;
          end else if (!in_use[p][s]) begin
            o.status = ST_INACTIVE;
          end else if (w.mode == MODE_LOCATE) begin
            o.status = ST_OK;
            o.byte_offset = offset_of(p, s);
          end else begin
            in_use[p][s] = 1'b0;
            if (freed[p].size() < SLOTS_PER_POOL) freed[p].insert(freed[p].size(), s);
            // trim the mark past trailing inactive slots
            while (mark[p] > 0 && mark[p] <= SLOTS_PER_POOL && !in_use[p][mark[p] - 1])
              mark[p]--;
            o.status = ST_OK;
          end
        end
        default: ;
      endcase
      o.high_water = HWOUT_W'(mark[p]);
      return o;
    endfunction

    function int pick_active(int p);
      int live [$];
      for (int i = 0; i < mark[p]; i++)
        if (in_use[p][i]) live.insert(live.size(), i);
      if (live.size() == 0) return -1;
      return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function void note_request(spa_in_t w);
      owed.insert(owed.size(), predict(w));
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch %0d: %s", mismatches, msg);
    endtask

    task check_reply(spa_out_t got);
      spa_out_t want;
      replies++;
      if (owed.size() == 0) begin
        report($sformatf("reply %0d arrived with none owed", replies));
      end else begin
        want = owed.pop_front();
        if (got.status !== want.status)
          report($sformatf("reply %0d status %0d, predicted %0d",
                           replies, got.status, want.status));
        if (got.granted_slot !== want.granted_slot)
          report($sformatf("reply %0d granted_slot %0d, predicted %0d",
                           replies, got.granted_slot, want.granted_slot));
        if (got.byte_offset !== want.byte_offset)
          report($sformatf("reply %0d byte_offset %0h, predicted %0h",
                           replies, got.byte_offset, want.byte_offset));
        if (got.high_water !== want.high_water)
          report($sformatf("reply %0d high_water %0d, predicted %0d",
                           replies, got.high_water, want.high_water));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  spa_in_t              in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  spa_out_t             out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [BYTES_W-1:0]   cfg_data_i;

  pool_tracker tracker;
  int send_idle_pct;
  int stall_pct;
  int hold_req;

  slot_pool_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Reply side: check each reply taken from the output, then decide the stall for the next cycle.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) tracker.check_reply(out_data_o);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no word moved in %0d cycles", WATCHDOG_CYCLES);
    $display("TEST FAILED");
    $finish;
  end

  function automatic spa_in_t req(logic [1:0] m, logic pl, int s);
    spa_in_t w;
    w.mode = m;
    w.pool = pl;
    w.slot = SLOT_W'(s);
    return w;
  endfunction

  function automatic spa_in_t random_request();
    spa_in_t w;
    int r;
    int s;
    r = $urandom_range(0, 99);
    w.pool = 1'($urandom_range(0, 1));
    w.slot = SLOT_W'($urandom_range(0, 1023));
    w.mode = MODE_ALLOC;
    if (r < 10) begin
      // noise: any mode, any slot, low slots half the time
      w.mode = 2'($urandom_range(MODE_ALLOC, MODE_UNUSED));
      if (r < 5) w.slot = SLOT_W'($urandom_range(0, 40));
    end else if (r >= 50) begin
      s = tracker.pick_active(int'(w.pool));
      if (s >= 0) begin
        w.slot = SLOT_W'(s);
        w.mode = (r < 80) ? MODE_FREE : MODE_LOCATE;
      end
    end
    return w;
  endfunction

  task automatic send_request(spa_in_t w);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_request(w);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (tracker.owed.size() != 0);
  endtask

  task automatic end_phase();
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= BYTES_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_reg(idx, BYTES_W'(val));
  endtask

  task automatic program_regs(int mat_cap, int tex_cap, int mat_b, int tex_b, int hdr_b);
    write_reg(CFG_MAT_CAP, mat_cap);
    write_reg(CFG_TEX_CAP, tex_cap);
    write_reg(CFG_MAT_BYTES, mat_b);
    write_reg(CFG_TEX_BYTES, tex_b);
    write_reg(CFG_HDR_BYTES, hdr_b);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_mix(int count, int hold_at);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        // pause until every reply is back
        in_valid_i <= 1'b0;
        wait_drained();
      end
      if (n == hold_at) hold_req = LONG_HOLD;
      send_request(random_request());
    end
    end_phase();
  endtask

  initial begin
    tracker = new();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Small pools and extreme sizes: fill, full, range, inactive, trim, reuse.
    program_regs(4, 2, 65535, 1, 65535);
    repeat (5) send_request(req(MODE_ALLOC, 1'b0, 0));
    repeat (3) send_request(req(MODE_ALLOC, 1'b1, 1023));
    send_request(req(MODE_LOCATE, 1'b0, 3));
    send_request(req(MODE_LOCATE, 1'b1, 1));
    send_request(req(MODE_LOCATE, 1'b0, 4));
    send_request(req(MODE_LOCATE, 1'b0, 1023));
    send_request(req(MODE_FREE, 1'b0, 1));
    send_request(req(MODE_FREE, 1'b0, 1));
    send_request(req(MODE_LOCATE, 1'b0, 1));
    send_request(req(MODE_FREE, 1'b0, 3));
    send_request(req(MODE_ALLOC, 1'b0, 0));
    send_request(req(MODE_UNUSED, 1'b0, 682));
    send_request(req(MODE_FREE, 1'b1, 1));
    send_request(req(MODE_FREE, 1'b1, 0));
    send_request(req(MODE_ALLOC, 1'b0, 0));
    send_request(req(MODE_ALLOC, 1'b0, 0));
    send_request(req(MODE_FREE, 1'b0, 3));
    end_phase();

    // Shrink pool zero below a freed index, pool one above the slot limit.
    program_regs(2, 2047, 1000, 65535, 0);
    send_request(req(MODE_ALLOC, 1'b0, 0));
    send_request(req(MODE_LOCATE, 1'b0, 3));
    send_request(req(MODE_ALLOC, 1'b0, 0));
    end_phase();

    // Zero capacity keeps pool zero full; pool one then starts at the header.
    program_regs(0, 1024, 256, 64, 64);
    send_request(req(MODE_ALLOC, 1'b0, 0));
    send_request(req(MODE_ALLOC, 1'b1, 0));
    send_request(req(MODE_LOCATE, 1'b1, 0));
    end_phase();

    program_regs(16, 8, $urandom_range(1, 65535), $urandom_range(1, 65535),
                 $urandom_range(0, 65535));
    run_mix(150, 30);

    send_idle_pct = 67;
    program_regs(1, 1024, 1, 65535, 0);
    run_mix(150, -1);

    send_idle_pct = 0;
    stall_pct = 67;
    program_regs(1024, 3, 65535, 256, 65535);
    run_mix(150, 40);

    send_idle_pct = 13;
    stall_pct = 13;
    program_regs(24, 2047, $urandom_range(1, 65535), $urandom_range(1, 65535),
                 $urandom_range(0, 65535));
    run_mix(150, -1);

    stall_pct = 0;
    repeat (40) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.owed.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
